/* hw/rtl/ascii_integer_parser_macros.svh */
// Assertion helpers, clocked on aclk and disabled during reset.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication.
`define AIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/aip_pkg.sv */
`timescale 1ns / 1ps

package aip_pkg;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_LC_X  = 8'h78;
    localparam logic [7:0] CHR_UC_X  = 8'h58;
    localparam logic [7:0] CHR_LC_A  = 8'h61;
    localparam logic [7:0] CHR_LC_F  = 8'h66;
    localparam logic [7:0] CHR_UC_A  = 8'h41;
    localparam logic [7:0] CHR_UC_F  = 8'h46;
    localparam logic [7:0] CHR_MINUS = 8'h2d;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [7:0] CHR_LF    = 8'h0a;

    localparam logic [3:0] HEX_LETTER_BIAS = 4'd9;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_DEC,
        CLS_HEXL,
        CLS_X,
        CLS_MINUS,
        CLS_SPACE,
        CLS_OTHER
    } char_cls_t;

    typedef struct packed {
        char_cls_t  cls;
        logic [3:0] digit;
        logic       last;
    } token_t;

endpackage

/* hw/rtl/aip_front.sv */
`timescale 1ns / 1ps

module aip_front
    import aip_pkg::*;
(
    input  logic [7:0] char_code,
    input  logic       last_char,
    output token_t     tok
);

    always_comb begin
        tok.last  = last_char;
        tok.digit = char_code[3:0];
        if (char_code == CHR_ZERO) begin
            tok.cls = CLS_ZERO;
        end else if (char_code > CHR_ZERO && char_code <= CHR_NINE) begin
            tok.cls = CLS_DEC;
        end else if ((char_code >= CHR_LC_A && char_code <= CHR_LC_F) ||
                     (char_code >= CHR_UC_A && char_code <= CHR_UC_F)) begin
            tok.cls   = CLS_HEXL;
            tok.digit = char_code[3:0] + HEX_LETTER_BIAS;
        end else if (char_code == CHR_LC_X || char_code == CHR_UC_X) begin
            tok.cls = CLS_X;
        end else if (char_code == CHR_MINUS) begin
            tok.cls = CLS_MINUS;
        end else if (char_code == CHR_SPACE || char_code == CHR_TAB ||
                     char_code == CHR_CR || char_code == CHR_LF) begin
            tok.cls = CLS_SPACE;
        end else begin
            tok.cls = CLS_OTHER;
        end
    end

endmodule

/* hw/rtl/aip_fifo.sv */
`timescale 1ns / 1ps

module aip_fifo
    import aip_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  token_t                     push_tok,
    output logic                       full,
    input  logic                       pop,
    output token_t                     pop_tok,
    output logic                       pop_valid,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t           entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_tok   = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

/* hw/rtl/aip_back.sv */
`timescale 1ns / 1ps

module aip_back
    import aip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        tok_valid,
    input  token_t      tok,
    output logic        tok_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_parse_error
);

    typedef enum logic [3:0] {
        ST_LEAD,
        ST_ZERO,
        ST_PDEC,
        ST_PHEX,
        ST_NEG,
        ST_NZERO,
        ST_NDEC,
        ST_NHEX,
        ST_TRAIL,
        ST_FAIL
    } parse_state_t;

    parse_state_t state_reg, state_next;
    logic [63:0]  acc_reg, acc_next;
    logic         out_valid_reg;
    logic [63:0]  out_value_reg;
    logic         out_error_reg;

    logic [63:0] digit_ext;
    logic [63:0] acc_x10;
    logic [63:0] acc_x16;
    logic        is_num;
    logic        is_hex;
    logic        pop;

    assign digit_ext = {60'd0, tok.digit};
    assign acc_x10   = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
    assign acc_x16   = {acc_reg[59:0], 4'b0000};
    assign is_num    = tok.cls inside {CLS_ZERO, CLS_DEC};
    assign is_hex    = tok.cls inside {CLS_ZERO, CLS_DEC, CLS_HEXL};

    // a last-character transaction needs the output slot
    assign tok_ready = !tok.last || !out_valid_reg || m_ready;
    assign pop       = tok_valid && tok_ready;

    always_comb begin
        state_next = ST_FAIL;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_LEAD: begin
                if (tok.cls == CLS_ZERO) begin
                    state_next = ST_ZERO;
                    acc_next   = '0;
                end else if (tok.cls == CLS_DEC) begin
                    state_next = ST_PDEC;
                    acc_next   = digit_ext;
                end else if (tok.cls == CLS_MINUS) begin
                    state_next = ST_NEG;
                end else if (tok.cls == CLS_SPACE) begin
                    state_next = ST_LEAD;
                end
            end
            ST_ZERO: begin
                if (is_num) begin
                    state_next = ST_PDEC;
                    acc_next   = digit_ext;
                end else if (tok.cls == CLS_X) begin
                    state_next = ST_PHEX;
                end else if (tok.cls == CLS_SPACE) begin
                    state_next = ST_TRAIL;
                end
            end
            ST_PDEC: begin
                if (is_num) begin
                    state_next = ST_PDEC;
                    acc_next   = acc_x10 + digit_ext;
                end else if (tok.cls == CLS_SPACE) begin
                    state_next = ST_TRAIL;
                end
            end
            ST_PHEX: begin
                if (is_hex) begin
                    state_next = ST_PHEX;
                    acc_next   = acc_x16 + digit_ext;
                end else if (tok.cls == CLS_SPACE) begin
                    state_next = ST_TRAIL;
                end
            end
            ST_NEG: begin
                if (tok.cls == CLS_ZERO) begin
                    state_next = ST_NZERO;
                    acc_next   = '0;
                end else if (tok.cls == CLS_DEC) begin
                    state_next = ST_NDEC;
                    acc_next   = 64'd0 - digit_ext;
                end
            end
            ST_NZERO: begin
                if (is_num) begin
                    state_next = ST_NDEC;
                    acc_next   = 64'd0 - digit_ext;
                end else if (tok.cls == CLS_X) begin
                    state_next = ST_NHEX;
                end else if (tok.cls == CLS_SPACE) begin
                    state_next = ST_TRAIL;
                end
            end
            ST_NDEC: begin
                if (is_num) begin
                    state_next = ST_NDEC;
                    acc_next   = acc_x10 - digit_ext;
                end else if (tok.cls == CLS_SPACE) begin
                    state_next = ST_TRAIL;
                end
            end
            ST_NHEX: begin
                if (is_hex) begin
                    state_next = ST_NHEX;
                    acc_next   = acc_x16 - digit_ext;
                end else if (tok.cls == CLS_SPACE) begin
                    state_next = ST_TRAIL;
                end
            end
            ST_TRAIL: begin
                if (tok.cls == CLS_SPACE) begin
                    state_next = ST_TRAIL;
                end
            end
            ST_FAIL: begin
                state_next = ST_FAIL;
            end
            default: begin
                state_next = ST_FAIL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LEAD;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_error_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (pop) begin
                if (tok.last) begin
                    state_reg     <= ST_LEAD;
                    acc_reg       <= '0;
                    out_valid_reg <= 1'b1;
                    out_error_reg <= (state_next == ST_FAIL);
                    out_value_reg <= (state_next == ST_FAIL) ? 64'd0 : acc_next;
                end else begin
                    state_reg <= state_next;
                    acc_reg   <= acc_next;
                end
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_value       = out_value_reg;
    assign m_parse_error = out_error_reg;

endmodule

/* hw/rtl/ascii_integer_parser.sv */
// Accepts one character per cycle; s_ready drops only while the token queue is full.
// A result is registered: the last character is queued at the accepting edge, then
// parsed into the output register once the parser pops it from the queue.
// Throughput: 1 character per cycle while s_ready is high, set by the combinational shift-add accumulate.
// Reset (aresetn low, synchronous): queue emptied, parser to leading white space,
// accumulator cleared, no result pending.
`timescale 1ns / 1ps
`include "ascii_integer_parser_macros.svh"

module ascii_integer_parser
    import aip_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_parse_error
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    token_t           in_tok;
    token_t           q_tok;
    logic             q_full;
    logic             q_valid;
    logic             q_ready;
    logic             push;
    logic             pop;
    logic [CNT_W-1:0] q_count;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    aip_front u_front (
        .char_code (s_char_code),
        .last_char (s_last_char),
        .tok       (in_tok)
    );

    aip_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_tok  (in_tok),
        .full      (q_full),
        .pop       (pop),
        .pop_tok   (q_tok),
        .pop_valid (q_valid),
        .count     (q_count)
    );

    aip_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tok_valid     (q_valid),
        .tok           (q_tok),
        .tok_ready     (q_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_parse_error (m_parse_error)
    );

    `AIP_ASSERT_NEXT(a_queue_count, 1'b1, q_count == $past(q_count) + CNT_W'($past(push)) - CNT_W'($past(pop)), "token queue count mismatch")
    `AIP_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= CNT_W'(FIFO_DEPTH), "token queue overfilled")
    `AIP_ASSERT_NOW(a_error_zero, m_valid && m_parse_error, m_value == 64'd0, "failed result with nonzero value")
    `AIP_ASSERT_NEXT(a_result_drains, m_valid && m_ready && !(pop && q_tok.last), !m_valid, "result held after transaction")

endmodule

/* bench/ascii_integer_parser_test.sv */
`timescale 1ns / 1ps

module ascii_integer_parser_test;
    import aip_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;

    typedef enum logic [3:0] {
        P_LEAD, P_ZERO, P_PDEC, P_PHEX, P_NEG, P_NZERO, P_NDEC, P_NHEX, P_TRAIL, P_FAIL
    } parse_state_t;

    typedef struct packed {
        logic [63:0] value;
        logic        parse_error;
    } parse_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        s_last_char;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_value;
    logic        m_parse_error;

    parse_state_t  parse_st = P_LEAD;
    logic [63:0]   value_acc = '0;
    parse_result_t expected_results[$];
    logic [7:0]    str_q[$];
    int            errors = 0;
    int            chars_sent = 0;
    int            stuck_cycles = 0;
    int            stall_left = 0;
    bit            no_gaps = 1'b0;

    ascii_integer_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_last_char   (s_last_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_parse_error (m_parse_error)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit is_ws(input logic [7:0] c);
        return c == CHR_SPACE || c == CHR_TAB || c == CHR_CR || c == CHR_LF;
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CHR_ZERO && c <= CHR_NINE;
    endfunction

    function automatic bit is_x(input logic [7:0] c);
        return c == CHR_LC_X || c == CHR_UC_X;
    endfunction

    // 16 means not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (is_dec(c)) return 5'(c - CHR_ZERO);
        if (c >= CHR_LC_A && c <= CHR_LC_F) return 5'(c - CHR_LC_A + 10);
        if (c >= CHR_UC_A && c <= CHR_UC_F) return 5'(c - CHR_UC_A + 10);
        return 5'd16;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return CHR_SPACE;
            1: return CHR_TAB;
            2: return CHR_CR;
            default: return CHR_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'(CHR_ZERO + r);
        if (r < 16) return 8'(CHR_LC_A + r - 10);
        return 8'(CHR_UC_A + r - 16);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic [4:0]  h;
        logic [63:0] d;
        parse_result_t r;
        h = hex_digit(c);
        d = {60'd0, h[3:0]};
        case (parse_st)
            P_LEAD: begin
                if (c == CHR_ZERO) begin
                    value_acc = '0;
                    parse_st = P_ZERO;
                end else if (is_dec(c)) begin
                    value_acc = d;
                    parse_st = P_PDEC;
                end else if (c == CHR_MINUS) begin
                    parse_st = P_NEG;
                end else if (!is_ws(c)) begin
                    parse_st = P_FAIL;
                end
            end
            P_ZERO, P_NZERO: begin
                if (is_dec(c)) begin
                    value_acc = (parse_st == P_ZERO) ? d : 64'd0 - d;
                    parse_st = (parse_st == P_ZERO) ? P_PDEC : P_NDEC;
                end else if (is_x(c)) begin
                    parse_st = (parse_st == P_ZERO) ? P_PHEX : P_NHEX;
                end else begin
                    parse_st = is_ws(c) ? P_TRAIL : P_FAIL;
                end
            end
            P_PDEC, P_NDEC: begin
                if (is_dec(c)) begin
                    value_acc = (parse_st == P_PDEC) ? value_acc * 64'd10 + d
                                                     : value_acc * 64'd10 - d;
                end else begin
                    parse_st = is_ws(c) ? P_TRAIL : P_FAIL;
                end
            end
            P_PHEX, P_NHEX: begin
                if (h < 5'd16) begin
                    value_acc = (parse_st == P_PHEX) ? (value_acc << 4) + d
                                                     : (value_acc << 4) - d;
                end else begin
                    parse_st = is_ws(c) ? P_TRAIL : P_FAIL;
                end
            end
            P_NEG: begin
                if (c == CHR_ZERO) begin
                    value_acc = '0;
                    parse_st = P_NZERO;
                end else if (is_dec(c)) begin
                    value_acc = 64'd0 - d;
                    parse_st = P_NDEC;
                end else begin
                    parse_st = P_FAIL;
                end
            end
            P_TRAIL: begin
                if (!is_ws(c)) parse_st = P_FAIL;
            end
            default: parse_st = P_FAIL;
        endcase
        if (last) begin
            r.parse_error = (parse_st == P_FAIL);
            r.value = r.parse_error ? 64'd0 : value_acc;
            expected_results.push_back(r);
            parse_st = P_LEAD;
            value_acc = '0;
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_char(c, last);
        @(negedge aclk);
    endtask

    task automatic send_str();
        foreach (str_q[i]) send_char(str_q[i], i == str_q.size() - 1);
        chars_sent += str_q.size();
        str_q.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    endtask

    task automatic make_number(input bit hex_form);
        int n;
        repeat ($urandom_range(0, 2)) str_q.push_back(pick_ws());
        if ($urandom_range(0, 1)) str_q.push_back(CHR_MINUS);
        if (hex_form) begin
            str_q.push_back(CHR_ZERO);
            str_q.push_back($urandom_range(0, 1) ? CHR_LC_X : CHR_UC_X);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 8);
            repeat (n) str_q.push_back(pick_hex());
        end else begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 8);
            repeat (n) str_q.push_back(8'(CHR_ZERO + $urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 2)) str_q.push_back(pick_ws());
    endtask

    task automatic test_directed();
        add_text("0");
        send_str();
        str_q.push_back(CHR_TAB);       // white space only
        send_str();
        add_text("-");                  // lone minus
        send_str();
        add_text("0x");                 // prefix without digits
        send_str();
        add_text("-0x");
        send_str();
        add_text("-0 ");
        send_str();
        add_text("0XaF");
        send_str();
        add_text("9");
        str_q.push_back(CHR_LF);
        send_str();
        add_text("-9");
        str_q.push_back(CHR_CR);
        send_str();
        add_text("1g");
        send_str();
        str_q.push_back(8'h00);
        send_str();
        str_q.push_back(8'hff);
        send_str();
        add_text("-x");
        send_str();
    endtask

    task automatic test_decimal(input int count);
        int target;
        target = chars_sent + count;
        while (chars_sent < target) begin
            make_number(1'b0);
            send_str();
        end
    endtask

    task automatic test_hex(input int count);
        int target;
        target = chars_sent + count;
        while (chars_sent < target) begin
            make_number(1'b1);
            send_str();
        end
    endtask

    task automatic test_back_to_back(input int count);
        int target;
        target = chars_sent + count;
        no_gaps = 1'b1;
        while (chars_sent < target) begin
            make_number($urandom_range(0, 1));
            send_str();
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_broken(input int count);
        int target;
        int pos;
        target = chars_sent + count;
        while (chars_sent < target) begin
            make_number($urandom_range(0, 1));
            pos = $urandom_range(0, str_q.size() - 1);
            if ($urandom_range(0, 1))
                str_q[pos] = 8'($urandom_range(0, 255));
            else
                str_q.insert(pos, $urandom_range(0, 1) ? CHR_MINUS : pick_hex());
            send_str();
        end
    endtask

    task automatic test_noise(input int count);
        int target;
        target = chars_sent + count;
        while (chars_sent < target) begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0: str_q.push_back(pick_hex());
                    1: str_q.push_back(pick_ws());
                    2: str_q.push_back(CHR_MINUS);
                    default: str_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            send_str();
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        parse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                flag_error($sformatf("unexpected result: value %h parse_error %b",
                                     m_value, m_parse_error));
            end else begin
                want = expected_results.pop_front();
                if (m_value !== want.value)
                    flag_error($sformatf("value mismatch: expected %h, got %h",
                                         want.value, m_value));
                if (m_parse_error !== want.parse_error)
                    flag_error($sformatf("parse_error mismatch: expected %b, got %b",
                                         want.parse_error, m_parse_error));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("ascii_integer_parser_test: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_char_code = 8'h00;
        s_last_char = 1'b0;
        m_ready = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_decimal(140);
        test_hex(140);
        test_back_to_back(70);
        test_broken(110);
        test_noise(70);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (errors == 0)
            $display("ascii_integer_parser_test: done, clean");
        else
            $display("ascii_integer_parser_test: done, errors");
        $finish;
    end

endmodule
